// ===== hdl/ght_pkg.sv =====
// Shared types, codes and sizes for the generational handle table.
package ght_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int LEN_W      = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = 16;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FIX
    } state_t;

    typedef enum logic [2:0] {
        OP_REMOVE = 3'd0,
        OP_CREATE = 3'd1,
        OP_MESH   = 3'd2,
        OP_XFORM  = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_BAD_REMOVE   = 3'd1,
        STAT_BAD_CREATE   = 3'd2,
        STAT_STALE_CREATE = 3'd3,
        STAT_BAD_MESH     = 3'd4,
        STAT_BAD_XFORM    = 3'd5
    } status_t;

    typedef struct packed {
        logic             alive;
        logic             mesh;
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] bp;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== hdl/ght_ram.sv =====
// Generic single-write, single-read RAM with registered read data (old data on collision).
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/generational_handle_table.sv =====
// Generational handle table: slot memory plus packed mesh list, read-modify-write sequencer.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: op; tdata: slot_index, generation
//  m_      | out | m_tvalid/m_tready  | tdata: status, handle_live, has_mesh,
//          |     |                    |        dense_position, mesh_count
//
// A request is accepted with slot and list-tail reads issued, then evaluated and
// written back. A remove of a slot with a mesh whose moved entry is a different
// slot adds a FIX step: the moved slot's back-pointer is a read-modify-write on
// the single slot memory port. After reset a clearing pass over all SLOT_COUNT
// (1024) slots zeroes the slot memory; no request is taken meanwhile. A stalled
// result holds the evaluate step; one further request may be accepted behind it.
module generational_handle_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] slot_index, [25:10] generation, [31:26] zero
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [2:0] status, [3] handle_live, [4] has_mesh,
                                   // [14:5] dense_position, [25:15] mesh_count, [31:26] zero
);

    localparam int IDX_W = ght_pkg::IDX_W;
    localparam int LEN_W = ght_pkg::LEN_W;
    localparam int GEN_W = ght_pkg::GEN_W;

    ght_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [2:0]       op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [GEN_W-1:0] gen_reg;
    logic [IDX_W-1:0] fix_addr_reg;
    logic [IDX_W-1:0] fix_pos_reg;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;

    // slot memory port
    logic                      slot_we;
    logic [IDX_W-1:0]          slot_waddr;
    ght_pkg::slot_entry_t      slot_wdata;
    logic [IDX_W-1:0]          slot_raddr;
    ght_pkg::slot_entry_t      slot_rdata;
    logic [ght_pkg::ENTRY_W-1:0] slot_rdata_raw;

    // packed list memory port
    logic             list_we;
    logic [IDX_W-1:0] list_waddr;
    logic [IDX_W-1:0] list_wdata;
    logic [IDX_W-1:0] list_raddr;
    logic [IDX_W-1:0] list_rdata;

    // evaluate step
    ght_pkg::slot_entry_t ex_entry;
    ght_pkg::status_t     ex_status;
    logic                 ex_slot_we;
    logic                 ex_list_we;
    logic [IDX_W-1:0]     ex_list_waddr;
    logic [IDX_W-1:0]     ex_list_wdata;
    logic [LEN_W-1:0]     ex_len;
    logic                 ex_fix;
    logic                 ex_match;
    logic                 ex_in_range;
    logic                 ex_live;
    logic                 ex_has_mesh;
    logic [IDX_W-1:0]     ex_pos;

    logic out_free;
    logic exec_go;

    assign out_free = !m_tvalid_reg || m_tready;
    assign exec_go  = (state_reg == ght_pkg::ST_EXEC) && out_free;

    ght_ram #(
        .WIDTH(ght_pkg::ENTRY_W),
        .DEPTH(ght_pkg::SLOT_COUNT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata_raw)
    );

    assign slot_rdata = ght_pkg::slot_entry_t'(slot_rdata_raw);

    ght_ram #(
        .WIDTH(IDX_W),
        .DEPTH(ght_pkg::SLOT_COUNT)
    ) u_list_ram (
        .aclk  (aclk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    // tail of the list is always the one a swap-remove needs
    assign list_raddr = IDX_W'(len_reg - LEN_W'(1));

    // evaluate the request against the slot entry read last cycle
    always_comb begin
        ex_in_range   = LEN_W'(idx_reg) < LEN_W'(ght_pkg::SLOT_COUNT);
        ex_match      = (gen_reg != '0) && ex_in_range && slot_rdata.alive &&
                        (slot_rdata.gen == gen_reg);
        ex_entry      = slot_rdata;
        ex_status     = ght_pkg::STAT_OK;
        ex_slot_we    = 1'b0;
        ex_list_we    = 1'b0;
        ex_list_waddr = slot_rdata.bp;
        ex_list_wdata = list_rdata;
        ex_len        = len_reg;
        ex_fix        = 1'b0;
        case (op_reg)
            ght_pkg::OP_REMOVE: begin
                if (!ex_match) begin
                    ex_status = ght_pkg::STAT_BAD_REMOVE;
                end else begin
                    ex_slot_we     = 1'b1;
                    ex_entry.alive = 1'b0;
                    ex_entry.mesh  = 1'b0;
                    if (slot_rdata.mesh && (len_reg != '0)) begin
                        // tail entry fills the gap
                        ex_list_we = 1'b1;
                        ex_len     = len_reg - LEN_W'(1);
                        ex_fix     = (list_rdata != idx_reg);
                    end
                end
            end
            ght_pkg::OP_CREATE: begin
                if ((gen_reg == '0) || !ex_in_range) begin
                    ex_status = ght_pkg::STAT_BAD_CREATE;
                end else if (slot_rdata.alive || (gen_reg <= slot_rdata.gen)) begin
                    ex_status = ght_pkg::STAT_STALE_CREATE;
                end else begin
                    ex_slot_we     = 1'b1;
                    ex_entry.alive = 1'b1;
                    ex_entry.gen   = gen_reg;
                end
            end
            ght_pkg::OP_MESH: begin
                if (!ex_match) begin
                    ex_status = ght_pkg::STAT_BAD_MESH;
                end else if (!slot_rdata.mesh &&
                             (len_reg < LEN_W'(ght_pkg::SLOT_COUNT))) begin
                    ex_slot_we    = 1'b1;
                    ex_entry.mesh = 1'b1;
                    ex_entry.bp   = IDX_W'(len_reg);
                    ex_list_we    = 1'b1;
                    ex_list_waddr = IDX_W'(len_reg);
                    ex_list_wdata = idx_reg;
                    ex_len        = len_reg + LEN_W'(1);
                end
            end
            ght_pkg::OP_XFORM: begin
                if (!ex_match || !slot_rdata.mesh) begin
                    ex_status = ght_pkg::STAT_BAD_XFORM;
                end
            end
            default: begin
                // query and unused codes change nothing
            end
        endcase
        ex_live     = (gen_reg != '0) && ex_in_range && ex_entry.alive &&
                      (ex_entry.gen == gen_reg);
        ex_has_mesh = ex_in_range && ex_entry.mesh;
        ex_pos      = ex_has_mesh ? ex_entry.bp : '0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ght_pkg::ST_CLEAR: begin
                if (clr_reg == IDX_W'(ght_pkg::SLOT_COUNT - 1)) begin
                    state_next = ght_pkg::ST_IDLE;
                end
            end
            ght_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ght_pkg::ST_EXEC;
                end
            end
            ght_pkg::ST_EXEC: begin
                if (exec_go) begin
                    state_next = ex_fix ? ght_pkg::ST_FIX : ght_pkg::ST_IDLE;
                end
            end
            ght_pkg::ST_FIX: begin
                state_next = ght_pkg::ST_IDLE;
            end
            default: begin
                state_next = ght_pkg::ST_CLEAR;
            end
        endcase
    end

    // memory ports and handshake per state
    always_comb begin
        s_tready   = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = ex_entry;
        slot_raddr = idx_reg;
        list_we    = 1'b0;
        list_waddr = ex_list_waddr;
        list_wdata = ex_list_wdata;
        clr_next   = clr_reg;
        case (state_reg)
            ght_pkg::ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + IDX_W'(1);
            end
            ght_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                slot_raddr = s_tdata[IDX_W-1:0];
            end
            ght_pkg::ST_EXEC: begin
                if (exec_go) begin
                    slot_we = ex_slot_we;
                    list_we = ex_list_we;
                    if (ex_fix) begin
                        // fetch the moved slot for its back-pointer update
                        slot_raddr = list_rdata;
                    end
                end
            end
            ght_pkg::ST_FIX: begin
                slot_we       = 1'b1;
                slot_waddr    = fix_addr_reg;
                slot_wdata    = slot_rdata;
                slot_wdata.bp = fix_pos_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        len_next = exec_go ? ex_len : len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ght_pkg::ST_CLEAR;
            clr_reg      <= '0;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            len_reg   <= len_next;
            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tuser;
            idx_reg <= s_tdata[IDX_W-1:0];
            gen_reg <= s_tdata[IDX_W +: GEN_W];
        end
        if (exec_go) begin
            fix_addr_reg <= list_rdata;
            fix_pos_reg  <= slot_rdata.bp;
            m_tdata_reg  <= {6'b0, ex_len, ex_pos, ex_has_mesh, ex_live, ex_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/ght_checker.sv =====
// Port-level assertions for the generational handle table, bound to the top level.
module ght_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: no accept right after an accept
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready asserted during evaluate step");

    // position is zero unless the slot holds a mesh
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tdata[14:5] == '0)
        else $error("dense position set without mesh");

    // a rejected removal never leaves the handle live
    a_bad_remove_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ght_pkg::STAT_BAD_REMOVE) |-> !m_tdata[3])
        else $error("failed removal reported a live handle");

    // list length bounded by slot count
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[25:15] <= ght_pkg::LEN_W'(ght_pkg::SLOT_COUNT))
        else $error("mesh count exceeds slot count");

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);
